@@ rtl/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache: controller states,
// the command and status bundles between controller and datapath, and the
// fixed field widths.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES_DEFAULT    = 8;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int KEY_WIDTH   = 32;
   localparam int RSP_WIDTH   = 32;
   localparam int CAP_WIDTH   = 4;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET  = 4'd2;
   localparam logic [RSP_WIDTH-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic REQ_PUT = 1'b0;
   localparam logic REQ_GET = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DISPATCH,
      ST_INSERT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic promote;
      logic value_write;
      logic value_read;
      logic evict;
      logic insert;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic is_get;
      logic full;
   } status_type;

endpackage

@@ rtl/lkvc_ram.sv @@
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/lkvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Request sequencer: lookup, then hit update, eviction or insertion, then
// a one-cycle response strobe.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  lkvc_pkg::status_type status,
   output lkvc_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   lkvc_pkg::state_type state_ff;
   lkvc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkvc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (start) state_in = lkvc_pkg::ST_LOOKUP;
         end
         lkvc_pkg::ST_LOOKUP: begin
            state_in = lkvc_pkg::ST_DISPATCH;
         end
         lkvc_pkg::ST_DISPATCH: begin
            if (!status.hit && !status.is_get && status.full) begin
               state_in = lkvc_pkg::ST_INSERT;
            end else begin
               state_in = lkvc_pkg::ST_RESPOND;
            end
         end
         lkvc_pkg::ST_INSERT: begin
            state_in = lkvc_pkg::ST_RESPOND;
         end
         lkvc_pkg::ST_RESPOND: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         lkvc_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         lkvc_pkg::ST_DISPATCH: begin
            if (status.hit) begin
               cmd.promote     = 1'b1;
               cmd.value_read  = status.is_get;
               cmd.value_write = !status.is_get;
            end else if (!status.is_get) begin
               // put miss: make room first when the store is at capacity
               cmd.evict  = status.full;
               cmd.insert = !status.full;
            end
         end
         lkvc_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
         end
         lkvc_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ rtl/lkvc_datapath.sv @@
// ----------------------------------------------------------------------------
// lkvc_datapath
// Key lanes with valid bits and recency ranks, value RAM, capacity register
// and response formatting.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
   parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEFAULT,
   parameter int DATA_WIDTH = lkvc_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lkvc_pkg::cmd_type                    cmd,
   output lkvc_pkg::status_type                 status,
   input  logic                                 req_type,
   input  logic signed [lkvc_pkg::KEY_WIDTH-1:0] req_key,
   input  logic signed [lkvc_pkg::KEY_WIDTH-1:0] req_write_value,
   input  logic                                 csr_we,
   input  logic [lkvc_pkg::CAP_WIDTH-1:0]       csr_wdata,
   output logic                                 rsp_hit,
   output logic signed [lkvc_pkg::RSP_WIDTH-1:0] rsp_read_value
);

   localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CMPW = (CW > lkvc_pkg::CAP_WIDTH) ? CW : lkvc_pkg::CAP_WIDTH;
   localparam int KW   = lkvc_pkg::KEY_WIDTH;
   localparam int OW   = lkvc_pkg::RSP_WIDTH;
   localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);

   // request registers
   logic                         req_type_ff;
   logic [KW-1:0]                req_key_ff;
   logic [KW-1:0]                req_wval_ff;
   logic [lkvc_pkg::CAP_WIDTH-1:0] capacity_ff;

   // entry lanes
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]      rank_ff [ENTRIES];
   logic [IW-1:0]      rank_in [ENTRIES];
   logic [KW-1:0]      key_ff  [ENTRIES];
   logic [CW-1:0]      count_ff, count_in;

   // lookup result
   logic [ENTRIES-1:0] match_ff;
   logic [IW-1:0]      hit_rank_ff;
   logic [IW-1:0]      hit_idx_ff;

   logic [ENTRIES-1:0] match_c;
   logic [IW-1:0]      hit_rank_c;
   logic [IW-1:0]      hit_idx_c;
   logic [ENTRIES-1:0] free_vec;
   logic [IW-1:0]      free_idx;
   logic [ENTRIES-1:0] victim_vec;
   logic [IW-1:0]      last_rank;
   logic [CMPW-1:0]    cap_ext;
   logic [CMPW-1:0]    cap_eff;

   logic                  ram_en;
   logic                  ram_we;
   logic [IW-1:0]         ram_addr;
   logic [DATA_WIDTH-1:0] ram_wdata;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic [OW-1:0]         widened;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         req_key_ff  <= req_key;
         req_wval_ff <= req_write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   // parallel compare and one-hot reductions
   always_comb begin
      hit_rank_c = '0;
      hit_idx_c  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_c[i] = valid_ff[i] && (key_ff[i] == req_key_ff);
         if (match_c[i]) begin
            hit_rank_c = hit_rank_c | rank_ff[i];
            hit_idx_c  = hit_idx_c | IW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         match_ff    <= match_c;
         hit_rank_ff <= hit_rank_c;
         hit_idx_ff  <= hit_idx_c;
      end
   end

   // lowest free slot, and the oldest entry (rank count-1)
   assign free_vec  = ~valid_ff & (valid_ff + ENTRIES'(1));
   assign last_rank = IW'(count_ff - CW'(1));

   always_comb begin
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == last_rank);
         if (free_vec[i]) free_idx = free_idx | IW'(i);
      end
   end

   always_comb begin
      cap_ext = CMPW'(capacity_ff);
      if (cap_ext == '0) begin
         cap_eff = CMPW'(1);
      end else if (cap_ext > ENTRIES_C) begin
         cap_eff = ENTRIES_C;
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign status.hit    = |match_ff;
   assign status.is_get = (req_type_ff == lkvc_pkg::REQ_GET);
   assign status.full   = (CMPW'(count_ff) >= cap_eff);

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (cmd.promote) begin
            if (match_ff[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         if (cmd.evict && victim_vec[i]) begin
            valid_in[i] = 1'b0;
            rank_in[i]  = '0;
         end
         if (cmd.insert) begin
            if (free_vec[i]) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
      if (cmd.evict) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.insert && free_vec[i]) key_ff[i] <= req_key_ff;
      end
   end

   assign ram_en   = cmd.value_read | cmd.value_write | cmd.insert;
   assign ram_we   = cmd.value_write | cmd.insert;
   assign ram_addr = cmd.insert ? free_idx : hit_idx_ff;

   generate
      if (DATA_WIDTH >= OW) begin : g_wide
         assign ram_wdata = DATA_WIDTH'(req_wval_ff);
         assign widened   = ram_rdata[OW-1:0];
      end else begin : g_narrow
         assign ram_wdata = req_wval_ff[DATA_WIDTH-1:0];
         assign widened   = {{(OW-DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
      end
   endgenerate

   lkvc_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_hit = status.hit;

   always_comb begin
      if (!status.is_get) begin
         rsp_read_value = '0;
      end else if (status.hit) begin
         rsp_read_value = widened;
      end else begin
         rsp_read_value = lkvc_pkg::MISS_VALUE;
      end
   end

endmodule

@@ rtl/lru_key_value_cache_core.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel   direction  handshake             payload
//   request   in         start & !busy         req_type, req_key, req_write_value
//   response  out        rsp_valid (1 cycle)   rsp_hit, rsp_read_value
//   csr       in         csr_we                csr_wdata (capacity)
//
// An item passes through accept, lookup, update and respond; a put miss at
// capacity adds an insert state, since it evicts and inserts in separate
// cycles. The sequencer handles one item at a time; busy is high until the
// response cycle ends. Reset clears valid bits, ranks and count at once; no
// clearing pass. Responses cannot be stalled.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
   parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEFAULT,
   parameter int DATA_WIDTH = lkvc_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_type,
   input  logic signed [lkvc_pkg::KEY_WIDTH-1:0] req_key,
   input  logic signed [lkvc_pkg::KEY_WIDTH-1:0] req_write_value,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic signed [lkvc_pkg::RSP_WIDTH-1:0] rsp_read_value,
   input  logic                                  csr_we,
   input  logic [lkvc_pkg::CAP_WIDTH-1:0]        csr_wdata
);

   lkvc_pkg::cmd_type    cmd;
   lkvc_pkg::status_type status;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lkvc_datapath #(
      .ENTRIES    (ENTRIES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value)
   );

endmodule

@@ rtl/lkvc_checker.sv @@
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the cache core, bound to every instance of the top.
// ----------------------------------------------------------------------------
module lkvc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic                           rsp_hit,
   input logic [lkvc_pkg::RSP_WIDTH-1:0] rsp_read_value
);

   // an accepted item keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // each item gives one strobe, never two in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // a response belongs to an item in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (busy && $past(busy)))
      else $error("response without an item in progress");

   // a miss reads back zero (put) or all ones (get)
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_read_value == '0 || rsp_read_value == lkvc_pkg::MISS_VALUE))
      else $error("miss returned a stored value");

endmodule

bind lru_key_value_cache_core lkvc_checker u_checker (.*);

@@ tb/sv/tb_lru_key_value_cache_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_core
// Self-checking bench for the LRU key/value cache core. A short table of puts
// and gets walks the evict and hit paths at the reset capacity. After it come
// random phases, each after a capacity write, that draw keys from a small pool so
// that hits and evictions are frequent. Every response is compared with a
// cycle-free model of the cache kept in the bench, or with the typed-in row.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_core;

   localparam int ENTRIES        = lkvc_pkg::ENTRIES_DEFAULT;
   localparam int KW             = lkvc_pkg::KEY_WIDTH;
   localparam int RW             = lkvc_pkg::RSP_WIDTH;
   localparam int CPW            = lkvc_pkg::CAP_WIDTH;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 105;
   localparam int KEY_POOL_SIZE  = 10;
   localparam int STALL_LIMIT    = 500;
   localparam int DIRECTED_COUNT = 15;

   typedef logic [CPW-1:0] cap_type;

   typedef struct packed {
      logic          hit;
      logic [RW-1:0] read_value;
   } cache_rsp_type;

   typedef struct packed {
      logic          req_type;
      logic [KW-1:0] key;
      logic [KW-1:0] write_value;
      logic          fixed;      // expected response typed in below
      logic          hit;
      logic [RW-1:0] read_value;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_type = lkvc_pkg::REQ_PUT;
   logic signed [KW-1:0]   req_key = '0;
   logic signed [KW-1:0]   req_write_value = '0;
   logic                   rsp_valid;
   logic                   rsp_hit;
   logic signed [RW-1:0]   rsp_read_value;
   logic                   csr_we = 1'b0;
   logic [CPW-1:0]         csr_wdata = '0;

   // Model of the cache contents
   logic                 model_valid [ENTRIES];
   logic [KW-1:0]        model_key   [ENTRIES];
   logic [RW-1:0]        model_value [ENTRIES];
   int                   model_rank  [ENTRIES];
   int                   model_count;
   logic [CPW-1:0]       model_capacity;

   cache_rsp_type        pending_rsp_q [$];
   int unsigned          error_count = 0;
   int unsigned          stall_cycles = 0;
   int                   burst_left = 0;
   logic                 gaps_on = 1'b1;
   logic [KW-1:0]        key_pool [KEY_POOL_SIZE];

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{lkvc_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
      '{lkvc_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
      '{lkvc_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
      '{lkvc_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{lkvc_pkg::REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000},
      // full at capacity two: the oldest key goes
      '{lkvc_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
      '{lkvc_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
      '{lkvc_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0},
      '{lkvc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{lkvc_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0},
      '{lkvc_pkg::REQ_PUT, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b0, 32'h0},
      '{lkvc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
      '{lkvc_pkg::REQ_GET, 32'h0000_0000, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'h1234_5678},
      '{lkvc_pkg::REQ_PUT, 32'h0000_0001, 32'h5555_5555, 1'b0, 1'b0, 32'h0},
      '{lkvc_pkg::REQ_GET, 32'h0000_0001, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0}
   };

   lru_key_value_cache_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Entries more recent than idx age by one; idx becomes most recent.
   function automatic void make_most_recent(input int idx);
      int old_rank;
      old_rank = model_rank[idx];
      for (int i = 0; i < ENTRIES; i++) begin
         if (model_valid[i] && model_rank[i] < old_rank) model_rank[i]++;
      end
      model_rank[idx] = 0;
   endfunction

   function automatic cache_rsp_type cache_access(input logic rtype,
                                                  input logic [KW-1:0] key,
                                                  input logic [KW-1:0] wval);
      cache_rsp_type res;
      int            idx;
      int            eff_cap;
      int            victim;
      int            slot;
      idx = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (idx < 0 && model_valid[i] && model_key[i] == key) idx = i;
      end
      eff_cap = model_capacity;
      if (eff_cap == 0) eff_cap = 1;
      if (eff_cap > ENTRIES) eff_cap = ENTRIES;
      res.hit = (idx >= 0);
      if (rtype == lkvc_pkg::REQ_PUT) begin
         res.read_value = '0;
         if (idx >= 0) begin
            model_value[idx] = wval;
            make_most_recent(idx);
         end else begin
            // evict only the single oldest, even if capacity was lowered
            if (model_count >= eff_cap) begin
               victim = -1;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (model_valid[i] && (victim < 0 || model_rank[i] > model_rank[victim]))
                     victim = i;
               end
               if (victim >= 0) begin
                  model_valid[victim] = 1'b0;
                  model_rank[victim] = 0;
                  model_count--;
               end
            end
            slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && !model_valid[i]) slot = i;
            end
            if (slot >= 0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (model_valid[i]) model_rank[i]++;
               end
               model_valid[slot] = 1'b1;
               model_key[slot] = key;
               model_value[slot] = wval;
               model_rank[slot] = 0;
               model_count++;
            end
         end
      end else if (idx >= 0) begin
         make_most_recent(idx);
         res.read_value = model_value[idx];
      end else begin
         res.read_value = lkvc_pkg::MISS_VALUE;
      end
      return res;
   endfunction

   // Hold the item until the core takes it, record its expected response, and at times pause.
   task automatic issue_request(input logic rtype, input logic [KW-1:0] key,
                                input logic [KW-1:0] wval, input logic fixed,
                                input cache_rsp_type fixed_rsp);
      cache_rsp_type predicted;
      int            gap;
      start <= 1'b1;
      req_type <= rtype;
      req_key <= key;
      req_write_value <= wval;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = cache_access(rtype, key, wval);
      if (fixed) predicted = fixed_rsp;
      pending_rsp_q = {pending_rsp_q, predicted};
      if (gaps_on) begin
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CPW-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      model_capacity = value;
   endtask

   always @(posedge clock) begin : rsp_check
      cache_rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_rsp_q.size() == 0) begin
            $error("response with no item outstanding");
            error_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0b, actual %0b", want.hit, rsp_hit);
               error_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %h, actual %h", want.read_value, rsp_read_value);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CPW-1:0]       cap_plan [4];
      logic [CPW-1:0]       cap;
      logic [KW-1:0]        key;
      cache_rsp_type        fixed_rsp;
      int                   pick;
      cap_plan = '{4'd8, 4'd1, 4'd15, 4'd0};
      for (int i = 0; i < ENTRIES; i++) begin
         model_valid[i] = 1'b0;
         model_key[i] = '0;
         model_value[i] = '0;
         model_rank[i] = 0;
      end
      model_count = 0;
      model_capacity = lkvc_pkg::CAP_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         fixed_rsp.hit = directed_rows[r].hit;
         fixed_rsp.read_value = directed_rows[r].read_value;
         issue_request(directed_rows[r].req_type, directed_rows[r].key,
                       directed_rows[r].write_value, directed_rows[r].fixed, fixed_rsp);
      end

      fixed_rsp = '0;
      for (int p = 0; p < PHASES; p++) begin
         // full capacity first, then lowered below the count, then the odd codes, then random ones
         if (p < 4) cap = cap_plan[p];
         else cap = cap_type'($urandom_range(0, 15));
         drain_responses();
         write_capacity(cap);
         gaps_on = (p % 3 != 1);
         foreach (key_pool[k]) key_pool[k] = $urandom;
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            if (pick < 45) begin
               issue_request(lkvc_pkg::REQ_PUT, key, $urandom, 1'b0, fixed_rsp);
            end else if (pick < 90) begin
               issue_request(lkvc_pkg::REQ_GET, key, $urandom, 1'b0, fixed_rsp);
            end else begin
               issue_request(1'($urandom_range(0, 1)), $urandom, $urandom, 1'b0,
                             fixed_rsp);
            end
         end
      end

      drain_responses();
      repeat (10) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp_q.size());
         error_count++;
      end
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

@@ files.f @@
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache_core.sv
rtl/lkvc_checker.sv
tb/sv/tb_lru_key_value_cache_core.sv
